FILE: hw/rtl/htc_pkg.sv
`default_nettype none

package htc_pkg;

  // Input item: raw sensor counts
  typedef struct packed {
    logic [13:0] raw_temperature;
    logic [11:0] raw_humidity;
  } in_item_t;

  // Result item: display bytes
  typedef struct packed {
    logic [6:0] temperature_byte;
    logic [6:0] humidity_byte;
  } out_item_t;

  // Q32 coefficients, truncated toward zero
  localparam logic [25:0] K_T1 = 26'd42949672;   // 0.01
  localparam logic [18:0] K_T2 = 19'd343597;     // 0.00008
  localparam logic [27:0] K_C2 = 28'd173946175;  // 0.0405
  localparam logic [13:0] K_C3 = 14'd12025;      // magnitude of -0.0000028

  // Q32 offsets
  localparam logic signed [41:0] OFS_T40 = 42'sd171798691840;  // 40.0
  localparam logic signed [41:0] OFS_T65 = 42'sd279172874240;  // 40.0 + 25.0
  localparam logic signed [41:0] OFS_C1  = 42'sd17179869184;   // 4.0
  localparam logic signed [47:0] OFS_H50 = 48'sd214748364800;  // 50.0 (tenths)

  // Display limits and step points in tenths
  localparam logic [9:0] T_MAX   = 10'd970;
  localparam logic [9:0] T_STEP1 = 10'd235;
  localparam logic [9:0] T_STEP2 = 10'd555;
  localparam logic [9:0] T_STEP3 = 10'd875;
  localparam logic [9:0] H_MAX   = 10'd999;
  localparam logic [9:0] H_LO    = 10'd490;
  localparam logic [9:0] H_HI    = 10'd951;

  // x / 10 as (x * 205) >> 11, exact for x below 1029
  localparam logic [7:0] DIV10_MUL = 8'd205;

endpackage

`default_nettype wire

FILE: hw/rtl/humidity_temp_compensation_top.sv
`default_nettype none

// Humidity and temperature compensation datapath.
// Input channel: in_item holds a raw 14-bit temperature count and a raw
// 12-bit humidity count; an item is taken at a rising edge with start high
// and busy low. busy is high only while reset is applied and for the first
// edge after it; otherwise the block takes one item every cycle.
// Result channel: out_item carries the temperature and humidity display
// bytes; out_strobe is high for exactly one cycle per item and the result
// is taken at the edge that ends that cycle. The receiver cannot stall, so
// nothing is held back: results leave in input order.
// Pipeline: six register stages. An item taken at one edge passes stages 1
// to 5 and the output register before it is on the result ports.
// Throughput: one item per clock; every stage passes its item on at each
// edge and nothing stalls, so the latency is set by the stage count alone.
// Reset: synchronous, active low; clears all stage valid bits so no stray
// strobe appears. There is no carried state between items.
module humidity_temp_compensation_top (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire htc_pkg::in_item_t in_item,
  output logic                  out_strobe,
  output htc_pkg::out_item_t    out_item
);
  import htc_pkg::*;

  logic accept;
  logic busy_r;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  // stage 1: first products
  logic [39:0] tmul_r;
  logic [23:0] rh_sq_r;
  logic [39:0] c2rh_r;
  logic [30:0] b_r;

  // stage 2: temperature in Q32, compensation magnitude
  logic signed [41:0] tc_r;
  logic               neg_r;
  logic [39:0]        mag_r;
  logic [37:0]        p3_r;
  logic [39:0]        c2rh2_r;
  logic [30:0]        b2_r;

  // stage 3: partial products, linear humidity, clamped temperature tenths
  logic [62:0]        prod_lo_r;
  logic [38:0]        prod_hi_r;
  logic               neg3_r;
  logic signed [41:0] rh_lin_r;
  logic [9:0]         t_cl_r;

  // stage 4: compensation term, temperature byte
  logic signed [40:0] comp_r;
  logic signed [41:0] rh_lin4_r;
  logic [6:0]         tbyte4_r;

  // stage 5: true humidity
  logic signed [42:0] rh_true_r;
  logic [6:0]         tbyte5_r;

  // output register
  out_item_t out_item_r;

  // combinational stage values
  logic signed [41:0] a_nxt;
  logic signed [41:0] tc_nxt;
  logic [39:0]        mag_nxt;
  logic signed [45:0] tc10;
  logic [13:0]        t_int;
  logic [9:0]         t_cl_nxt;
  logic signed [41:0] rh_lin_nxt;
  logic [39:0]        r_sum;
  logic signed [40:0] comp_nxt;
  logic [10:0]        t_s1, t_s2, t_s3;
  logic [18:0]        t_div;
  logic [6:0]         tbyte_nxt;
  logic signed [47:0] rt48;
  logic signed [47:0] h_v;
  logic [15:0]        h_int;
  logic [9:0]         h_cl;
  logic [9:0]         h_adj;
  logic [17:0]        h_div;
  logic [6:0]         hbyte_nxt;

  assign accept = start && !busy_r;

  // busy during reset and until the first edge after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // stage 1: independent products of the raw counts
  always_ff @(posedge clk) begin
    tmul_r  <= 40'(in_item.raw_temperature) * 40'(K_T1);
    rh_sq_r <= 24'(in_item.raw_humidity) * 24'(in_item.raw_humidity);
    c2rh_r  <= 40'(in_item.raw_humidity) * 40'(K_C2);
    b_r     <= 31'(K_T1) + 31'(in_item.raw_humidity) * 31'(K_T2);
  end

  // stage 2: offsets, sign and magnitude of (tC - 25)
  always_comb begin
    tc_nxt  = $signed({2'b00, tmul_r}) - OFS_T40;
    a_nxt   = $signed({2'b00, tmul_r}) - OFS_T65;
    mag_nxt = a_nxt[41] ? 40'(-a_nxt) : a_nxt[39:0];
  end

  always_ff @(posedge clk) begin
    tc_r    <= tc_nxt;
    neg_r   <= a_nxt[41];
    mag_r   <= mag_nxt;
    p3_r    <= 38'(rh_sq_r) * 38'(K_C3);
    c2rh2_r <= c2rh_r;
    b2_r    <= b_r;
  end

  // stage 3: split product, linear humidity, temperature tenths
  always_comb begin
    rh_lin_nxt = $signed({2'b00, c2rh2_r}) - $signed({4'b0000, p3_r}) - OFS_C1;
    tc10       = ($signed({{4{tc_r[41]}}, tc_r}) <<< 3)
               + ($signed({{4{tc_r[41]}}, tc_r}) <<< 1);
    t_int      = (tc10 <= 46'sd0) ? 14'd0 : 14'(tc10[45:32]);
    t_cl_nxt   = (t_int > 14'(T_MAX)) ? T_MAX : t_int[9:0];
  end

  always_ff @(posedge clk) begin
    prod_lo_r <= 63'(mag_r[31:0]) * 63'(b2_r);
    prod_hi_r <= 39'(mag_r[39:32]) * 39'(b2_r);
    neg3_r    <= neg_r;
    rh_lin_r  <= rh_lin_nxt;
    t_cl_r    <= t_cl_nxt;
  end

  // stage 4: compensation in Q32 (truncated toward zero), temperature byte
  always_comb begin
    r_sum     = 40'(prod_hi_r) + 40'(prod_lo_r[62:32]);
    comp_nxt  = neg3_r ? -$signed({1'b0, r_sum}) : $signed({1'b0, r_sum});
    t_s1      = (11'(t_cl_r) > 11'(T_STEP1)) ? 11'(t_cl_r) + 11'd10 : 11'(t_cl_r);
    t_s2      = (t_s1 > 11'(T_STEP2)) ? t_s1 + 11'd10 : t_s1;
    t_s3      = (t_s2 > 11'(T_STEP3)) ? t_s2 + 11'd10 : t_s2;
    t_div     = 19'(t_s3) * 19'(DIV10_MUL);
    tbyte_nxt = 7'(t_div[18:11]);
  end

  always_ff @(posedge clk) begin
    comp_r    <= comp_nxt;
    rh_lin4_r <= rh_lin_r;
    tbyte4_r  <= tbyte_nxt;
  end

  // stage 5: compensated humidity
  always_ff @(posedge clk) begin
    rh_true_r <= $signed({{2{comp_r[40]}}, comp_r}) + $signed({rh_lin4_r[41], rh_lin4_r});
    tbyte5_r  <= tbyte4_r;
  end

  // stage 6: humidity tenths, clamp, band offset, byte
  always_comb begin
    rt48      = $signed({{5{rh_true_r[42]}}, rh_true_r});
    h_v       = (rt48 <<< 3) + (rt48 <<< 1) - OFS_H50;
    h_int     = (h_v <= 48'sd0) ? 16'd0 : h_v[47:32];
    h_cl      = (h_int > 16'(H_MAX)) ? H_MAX : h_int[9:0];
    h_adj     = ((h_cl > H_LO) && (h_cl < H_HI)) ? h_cl - 10'd10 : h_cl;
    h_div     = 18'(h_adj) * 18'(DIV10_MUL);
    hbyte_nxt = 7'(h_div[17:11]) + 7'd4;
  end

  always_ff @(posedge clk) begin
    out_item_r.temperature_byte <= tbyte5_r;
    out_item_r.humidity_byte    <= hbyte_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  // every taken item gives a strobe after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("result strobe missing after pipeline depth");

  // no strobe straight after a reset edge
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

  // result bytes stay in their display ranges
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.temperature_byte <= 7'd100))
    else $error("temperature byte out of range");

  a_humi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_item.humidity_byte >= 7'd4) && (out_item.humidity_byte <= 7'd103)))
    else $error("humidity byte out of range");

endmodule

`default_nettype wire
